[rtl/mh2_pkg.sv]
// Shared types and constants for the 32-bit MurmurHash2 block.
// Used by mh2_ctrl, mh2_dpath and murmur2_hash_32_top; no dependencies.
package mh2_pkg;

  localparam logic [31:0] MH_MUL    = 32'h5bd1e995;
  localparam int          SHIFT_K   = 24;
  localparam int          SHIFT_F1  = 13;
  localparam int          SHIFT_F2  = 15;

  localparam int          ADDR_W    = 3;
  // paddr[2] picks the register word; only word 0 (hash_seed) exists
  localparam logic        REG_SEED  = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_K1,
    S_K2,
    S_HMIX,
    S_TAIL,
    S_FIN
  } state_t;

  // at most one op per cycle on the shared multiplier
  typedef enum logic [2:0] {
    OP_NONE,
    OP_K1,
    OP_K2,
    OP_HMIX,
    OP_TAIL,
    OP_FIN
  } op_t;

  typedef struct packed {
    logic load;   // capture input transaction
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic last;     // captured item is the last of its message
    logic out_free; // output register can take a result this cycle
  } dp_stat_t;

endpackage

[rtl/mh2_ctrl.sv]
// Sequencer for the MurmurHash2 datapath: walks each item through its mix steps.
// Depends on mh2_pkg.
module mh2_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [2:0]       in_valid_bytes,
  input  logic             in_last_item,
  output logic             in_ready,
  output mh2_pkg::dp_cmd_t cmd,
  input  mh2_pkg::dp_stat_t stat
);

  mh2_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mh2_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.op    = mh2_pkg::OP_NONE;
    unique case (state_r)
      mh2_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          // four or more bytes saturate to a full word
          if (in_valid_bytes[2]) begin
            state_nxt = mh2_pkg::S_K1;
          end else if (in_valid_bytes[1:0] != 2'd0) begin
            state_nxt = mh2_pkg::S_TAIL;
          end else if (in_last_item) begin
            state_nxt = mh2_pkg::S_FIN;
          end
        end
      end
      mh2_pkg::S_K1: begin
        cmd.op    = mh2_pkg::OP_K1;
        state_nxt = mh2_pkg::S_K2;
      end
      mh2_pkg::S_K2: begin
        cmd.op    = mh2_pkg::OP_K2;
        state_nxt = mh2_pkg::S_HMIX;
      end
      mh2_pkg::S_HMIX: begin
        cmd.op    = mh2_pkg::OP_HMIX;
        state_nxt = stat.last ? mh2_pkg::S_FIN : mh2_pkg::S_IDLE;
      end
      mh2_pkg::S_TAIL: begin
        cmd.op    = mh2_pkg::OP_TAIL;
        state_nxt = stat.last ? mh2_pkg::S_FIN : mh2_pkg::S_IDLE;
      end
      mh2_pkg::S_FIN: begin
        // hold until the previous result has left the output register
        if (stat.out_free) begin
          cmd.op    = mh2_pkg::OP_FIN;
          state_nxt = mh2_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mh2_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/mh2_dpath.sv]
// MurmurHash2 datapath: running hash, word mix register, one shared multiplier
// and the result register. Depends on mh2_pkg; driven by mh2_ctrl.
module mh2_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  mh2_pkg::dp_cmd_t  cmd,
  output mh2_pkg::dp_stat_t stat,
  input  logic [31:0]       hash_seed,
  input  logic [31:0]       in_data_word,
  input  logic [2:0]        in_valid_bytes,
  input  logic              in_first_item,
  input  logic              in_last_item,
  input  logic [30:0]       in_message_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_hash_value
);

  logic [31:0] h_r, h_nxt;
  logic [31:0] k_r, k_nxt;
  logic [31:0] word_r;
  logic [1:0]  tail_n_r;
  logic        last_r;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r;

  logic [31:0] tail_word;
  logic [31:0] mul_a;
  logic [31:0] prod;

  always_comb begin
    case (tail_n_r)
      2'd1:    tail_word = {24'd0, word_r[7:0]};
      2'd2:    tail_word = {16'd0, word_r[15:0]};
      default: tail_word = {8'd0, word_r[23:0]};
    endcase
  end

  always_comb begin
    case (cmd.op)
      mh2_pkg::OP_K1:   mul_a = word_r;
      mh2_pkg::OP_K2:   mul_a = k_r;
      mh2_pkg::OP_HMIX: mul_a = h_r;
      mh2_pkg::OP_TAIL: mul_a = h_r ^ tail_word;
      mh2_pkg::OP_FIN:  mul_a = h_r ^ (h_r >> mh2_pkg::SHIFT_F1);
      default:          mul_a = h_r;
    endcase
  end

  // low 32 bits of the product only
  assign prod = mul_a * mh2_pkg::MH_MUL;

  always_comb begin
    h_nxt = h_r;
    k_nxt = k_r;
    if (cmd.load && in_first_item) begin
      h_nxt = hash_seed ^ {1'b0, in_message_length};
    end
    case (cmd.op)
      mh2_pkg::OP_K1:   k_nxt = prod ^ (prod >> mh2_pkg::SHIFT_K);
      mh2_pkg::OP_K2:   k_nxt = prod;
      mh2_pkg::OP_HMIX: h_nxt = prod ^ k_r;
      mh2_pkg::OP_TAIL: h_nxt = prod;
      mh2_pkg::OP_FIN:  h_nxt = prod ^ (prod >> mh2_pkg::SHIFT_F2);
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.op == mh2_pkg::OP_FIN) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r         <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (cmd.load) begin
      word_r   <= in_data_word;
      tail_n_r <= in_valid_bytes[1:0];
      last_r   <= in_last_item;
    end
    if (cmd.op == mh2_pkg::OP_FIN) begin
      out_hash_r <= h_nxt;
    end
  end

  assign stat.last      = last_r;
  assign stat.out_free  = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  a_fin_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == mh2_pkg::OP_FIN) |-> (!out_valid_r || out_ready))
    else $error("finalize overwrote a pending result");

  a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == mh2_pkg::OP_FIN) |=> (out_valid_r && (out_hash_r == h_r)))
    else $error("result register does not match running hash");

  a_k2_after_k1: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == mh2_pkg::OP_K2) |-> ($past(cmd.op) == mh2_pkg::OP_K1))
    else $error("second word multiply without first");

endmodule

[rtl/murmur2_hash_32_top.sv]
// 32-bit MurmurHash2 over a byte message sent as little-endian 32-bit words.
// A full word goes through acceptance, two word multiplies and a hash fold; a
// 1-3 byte tail word through acceptance and a tail mix; an empty item through
// acceptance alone. A last item adds the closing mix, held while a result is
// pending. Every mix step uses the single 32x32 datapath multiplier in turn.
// A finished hash sits in an output register, so the next message can start
// while the result waits to be taken. hash_seed is at byte address 0 of the
// APB-style port; set it while no message is in flight.
// Depends on mh2_pkg, mh2_ctrl and mh2_dpath.
module murmur2_hash_32_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [31:0]                in_data_word,
  input  logic [2:0]                 in_valid_bytes,
  input  logic                       in_first_item,
  input  logic                       in_last_item,
  input  logic [30:0]                in_message_length,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                out_hash_value,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mh2_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [31:0] seed_r;
  logic        cfg_wr;

  mh2_pkg::dp_cmd_t  cmd;
  mh2_pkg::dp_stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
    end else if (cfg_wr && (paddr[2] == mh2_pkg::REG_SEED)) begin
      seed_r <= pwdata;
    end
  end

  assign prdata = (paddr[2] == mh2_pkg::REG_SEED) ? seed_r : 32'd0;

  mh2_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_valid_bytes (in_valid_bytes),
    .in_last_item   (in_last_item),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .stat           (stat)
  );

  mh2_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .hash_seed         (seed_r),
    .in_data_word      (in_data_word),
    .in_valid_bytes    (in_valid_bytes),
    .in_first_item     (in_first_item),
    .in_last_item      (in_last_item),
    .in_message_length (in_message_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hash_value    (out_hash_value)
  );

endmodule
